/* rtl/core/bocp_pkg.sv */
package bocp_pkg;

    localparam int NUM_LANES   = 4;
    localparam int CUR_W       = 16;
    localparam int THR_W       = 18;
    localparam int TICK_W      = 24;
    localparam int TRIP_W      = 16;
    localparam int COUNT_WIDTH = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INST_MAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INST_A      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_A       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_TICKS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN    = 3'd7;

    localparam logic signed [CUR_W-1:0] RST_LIMIT = 16'sh7FFF;
    localparam logic [TICK_W-1:0]       RST_TICKS = 24'hFFFFFF;

    localparam logic signed [THR_W-1:0] OFS_LONG_SET  = 18'sd48;
    localparam logic signed [THR_W-1:0] OFS_LONG_CLR  = 18'sd32;
    localparam logic signed [THR_W-1:0] OFS_SHORT_SET = 18'sd96;
    localparam logic signed [THR_W-1:0] OFS_SHORT_CLR = 18'sd80;
    localparam logic signed [THR_W-1:0] OFS_RELEASE   = 18'sd128;

    typedef struct packed {
        logic signed [CUR_W-1:0]  inst_max;
        logic signed [CUR_W-1:0]  inst_a;
        logic signed [CUR_W-1:0]  avg_max;
        logic signed [CUR_W-1:0]  avg_a;
        logic        [TICK_W-1:0] long_ticks;
        logic        [TICK_W-1:0] short_ticks;
        logic        [TICK_W-1:0] clear_ticks;
        logic                     shutdown;
    } t_cfg;

    typedef struct packed {
        logic signed [THR_W-1:0] inst;
        logic signed [THR_W-1:0] long_set;
        logic signed [THR_W-1:0] long_clr;
        logic signed [THR_W-1:0] short_set;
        logic signed [THR_W-1:0] short_clr;
        logic signed [THR_W-1:0] rel_lim;
    } t_thr;

    typedef struct packed {
        logic gt_inst;
        logic ge_long;
        logic le_long;
        logic ge_short;
        logic le_short;
        logic le_rel;
    } t_flags;

    typedef struct packed {
        logic inst_trip;
        logic long_up;
        logic long_clr;
        logic short_up;
        logic short_clr;
        logic rel_ok;
    } t_cond;

    typedef struct packed {
        logic              fault_latched;
        logic              overcurrent_set;
        logic              pwm_disable_pulse;
        logic [TRIP_W-1:0] trip_count;
    } t_result;

    function automatic t_thr make_thr(logic signed [CUR_W-1:0] inst,
                                      logic signed [CUR_W-1:0] avg);
        t_thr                    thr;
        logic signed [THR_W-1:0] avg_x;
        avg_x         = THR_W'(avg);
        thr.inst      = THR_W'(inst);
        thr.long_set  = avg_x + OFS_LONG_SET;
        thr.long_clr  = avg_x + OFS_LONG_CLR;
        thr.short_set = avg_x + OFS_SHORT_SET;
        thr.short_clr = avg_x + OFS_SHORT_CLR;
        thr.rel_lim   = avg_x - OFS_RELEASE;
        return thr;
    endfunction

endpackage

/* rtl/core/bocp_in_if.sv */
interface bocp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bocp_pkg::CUR_W-1:0]    current_a;
    logic signed [bocp_pkg::CUR_W-1:0]    current_b;
    logic signed [bocp_pkg::CUR_W-1:0]    current_c;
    logic signed [bocp_pkg::CUR_W-1:0]    current_d;

    modport source(output valid, current_a, current_b, current_c, current_d, input ready);
    modport sink(input valid, current_a, current_b, current_c, current_d, output ready);
endinterface

/* rtl/core/bocp_out_if.sv */
interface bocp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          fault_latched;
    logic                          overcurrent_set;
    logic                          pwm_disable_pulse;
    logic [bocp_pkg::TRIP_W-1:0]   trip_count;

    modport source(output valid, fault_latched, overcurrent_set, pwm_disable_pulse,
                   trip_count, input ready);
    modport sink(input valid, fault_latched, overcurrent_set, pwm_disable_pulse,
                 trip_count, output ready);
endinterface

/* rtl/core/bocp_lane.sv */
module bocp_lane (
    input  logic signed [bocp_pkg::CUR_W-1:0] i_current,
    input  bocp_pkg::t_thr                    i_thr,
    output bocp_pkg::t_flags                  o_flags
);

    logic signed [bocp_pkg::THR_W-1:0] w_cur;

    assign w_cur = bocp_pkg::THR_W'(i_current);

    assign o_flags.gt_inst  = (w_cur >  i_thr.inst);
    assign o_flags.ge_long  = (w_cur >= i_thr.long_set);
    assign o_flags.le_long  = (w_cur <= i_thr.long_clr);
    assign o_flags.ge_short = (w_cur >= i_thr.short_set);
    assign o_flags.le_short = (w_cur <= i_thr.short_clr);
    assign o_flags.le_rel   = (w_cur <= i_thr.rel_lim);

endmodule

/* rtl/core/bocp_merge.sv */
module bocp_merge (
    input  bocp_pkg::t_flags i_lanes [bocp_pkg::NUM_LANES],
    input  bocp_pkg::t_flags i_chan_a,
    output bocp_pkg::t_cond  o_cond
);

    // The largest current exceeds a level when any lane does, and stays at or
    // below a level only when every lane does; channel A's flag is ORed into each.
    always_comb begin
        logic any_gt_inst, any_ge_long, any_ge_short;
        logic all_le_long, all_le_short, all_le_rel;
        any_gt_inst  = 1'b0;
        any_ge_long  = 1'b0;
        any_ge_short = 1'b0;
        all_le_long  = 1'b1;
        all_le_short = 1'b1;
        all_le_rel   = 1'b1;
        for (int k = 0; k < bocp_pkg::NUM_LANES; k++) begin
            any_gt_inst  = any_gt_inst  | i_lanes[k].gt_inst;
            any_ge_long  = any_ge_long  | i_lanes[k].ge_long;
            any_ge_short = any_ge_short | i_lanes[k].ge_short;
            all_le_long  = all_le_long  & i_lanes[k].le_long;
            all_le_short = all_le_short & i_lanes[k].le_short;
            all_le_rel   = all_le_rel   & i_lanes[k].le_rel;
        end
        o_cond.inst_trip = any_gt_inst  | i_chan_a.gt_inst;
        o_cond.long_up   = any_ge_long  | i_chan_a.ge_long;
        o_cond.long_clr  = all_le_long  | i_chan_a.le_long;
        o_cond.short_up  = any_ge_short | i_chan_a.ge_short;
        o_cond.short_clr = all_le_short | i_chan_a.le_short;
        o_cond.rel_ok    = all_le_rel   | i_chan_a.le_rel;
    end

endmodule

/* rtl/core/bocp_state.sv */
module bocp_state #(
    parameter int COUNT_WIDTH = bocp_pkg::COUNT_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  bocp_pkg::t_cond   i_cond,
    input  bocp_pkg::t_cfg    i_cfg,
    output bocp_pkg::t_result o_result
);

    localparam int CMP_W = (COUNT_WIDTH > bocp_pkg::TICK_W) ? COUNT_WIDTH : bocp_pkg::TICK_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                          r_fault, n_fault;
    logic [COUNT_WIDTH-1:0]        r_long, n_long;
    logic [COUNT_WIDTH-1:0]        r_short, n_short;
    logic [COUNT_WIDTH-1:0]        r_rel, n_rel;
    logic [bocp_pkg::TRIP_W-1:0]   r_trips, n_trips;
    logic                          w_set, w_pulse;

    function automatic logic [COUNT_WIDTH-1:0] inc_sat(logic [COUNT_WIDTH-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic reached(logic [COUNT_WIDTH-1:0] c,
                                     logic [bocp_pkg::TICK_W-1:0] lim);
        return CMP_W'(c) >= CMP_W'(lim);
    endfunction

    always_comb begin
        n_fault = r_fault;
        n_long  = r_long;
        n_short = r_short;
        n_rel   = r_rel;
        n_trips = r_trips;
        w_set   = 1'b0;
        w_pulse = 1'b0;
        if (!r_fault) begin
            if (i_cond.inst_trip) begin
                if (i_cfg.shutdown) begin
                    w_set   = 1'b1;
                    n_fault = 1'b1;
                end else begin
                    w_pulse = 1'b1;
                    n_trips = r_trips + 1'b1;
                end
            end
            if (i_cond.long_up) begin
                n_long = inc_sat(r_long);
            end else if (i_cond.long_clr) begin
                n_long = '0;
            end
            if (reached(n_long, i_cfg.long_ticks)) begin
                w_set   = 1'b1;
                n_fault = 1'b1;
            end
            if (i_cond.short_up) begin
                n_short = inc_sat(r_short);
            end else if (i_cond.short_clr) begin
                n_short = '0;
            end
            if (reached(n_short, i_cfg.short_ticks)) begin
                n_short = '0;
                w_set   = 1'b1;
                n_fault = 1'b1;
            end
            n_rel = '0;
        end else begin
            if (i_cond.rel_ok) begin
                n_rel = inc_sat(r_rel);
                if (reached(n_rel, i_cfg.clear_ticks)) begin
                    n_rel   = '0;
                    n_long  = '0;
                    n_short = '0;
                    n_fault = 1'b0;
                end
            end else begin
                n_rel = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= 1'b0;
            r_long  <= '0;
            r_short <= '0;
            r_rel   <= '0;
            r_trips <= '0;
        end else if (i_en) begin
            r_fault <= n_fault;
            r_long  <= n_long;
            r_short <= n_short;
            r_rel   <= n_rel;
            r_trips <= n_trips;
        end
    end

    assign o_result.fault_latched     = n_fault;
    assign o_result.overcurrent_set   = w_set;
    assign o_result.pwm_disable_pulse = w_pulse;
    assign o_result.trip_count        = n_trips;

endmodule

/* rtl/core/boost_overcurrent_protector_unit.sv */
// Channel    Direction  Transaction contents
// i_sample   in         current_a, current_b, current_c, current_d
// o_result   out        fault_latched, overcurrent_set, pwm_disable_pulse, trip_count
// i_cfg_*    in         register index and write data, one write per enabled cycle
//
// One sample enters per cycle while the result is not stalled; its result passes both stages.
// The first stage compares the four currents in parallel lanes and registers the
// merged conditions; the second stage updates the counters and the result register.
// Reset clears the fault, the counters, the trip count and both valid stages.
// A stalled result holds both stages; a new sample is taken whenever the first
// stage is empty or moves on in the same cycle.
module boost_overcurrent_protector_unit #(
    parameter int COUNT_WIDTH = bocp_pkg::COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bocp_in_if.sink                             i_sample,
    bocp_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [bocp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bocp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bocp_pkg::t_cfg    r_cfg;
    bocp_pkg::t_thr    w_thr_max, w_thr_a;
    bocp_pkg::t_flags  w_lanes [bocp_pkg::NUM_LANES];
    bocp_pkg::t_flags  w_flags_a;
    bocp_pkg::t_cond   w_cond, r_cond;
    bocp_pkg::t_result w_res, r_out;
    logic              r_s1_valid, r_out_valid;
    logic              w_in_take, w_s2_take;
    logic signed [bocp_pkg::CUR_W-1:0] w_cur [bocp_pkg::NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inst_max    <= bocp_pkg::RST_LIMIT;
            r_cfg.inst_a      <= bocp_pkg::RST_LIMIT;
            r_cfg.avg_max     <= bocp_pkg::RST_LIMIT;
            r_cfg.avg_a       <= bocp_pkg::RST_LIMIT;
            r_cfg.long_ticks  <= bocp_pkg::RST_TICKS;
            r_cfg.short_ticks <= bocp_pkg::RST_TICKS;
            r_cfg.clear_ticks <= bocp_pkg::RST_TICKS;
            r_cfg.shutdown    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bocp_pkg::CFG_INST_MAX: begin
                    r_cfg.inst_max <= i_cfg_data[bocp_pkg::CUR_W-1:0];
                end
                bocp_pkg::CFG_INST_A: begin
                    r_cfg.inst_a <= i_cfg_data[bocp_pkg::CUR_W-1:0];
                end
                bocp_pkg::CFG_AVG_MAX: begin
                    r_cfg.avg_max <= i_cfg_data[bocp_pkg::CUR_W-1:0];
                end
                bocp_pkg::CFG_AVG_A: begin
                    r_cfg.avg_a <= i_cfg_data[bocp_pkg::CUR_W-1:0];
                end
                bocp_pkg::CFG_LONG_TICKS: begin
                    r_cfg.long_ticks <= i_cfg_data[bocp_pkg::TICK_W-1:0];
                end
                bocp_pkg::CFG_SHORT_TICKS: begin
                    r_cfg.short_ticks <= i_cfg_data[bocp_pkg::TICK_W-1:0];
                end
                bocp_pkg::CFG_CLEAR_TICKS: begin
                    r_cfg.clear_ticks <= i_cfg_data[bocp_pkg::TICK_W-1:0];
                end
                bocp_pkg::CFG_SHUTDOWN: begin
                    r_cfg.shutdown <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_thr_max = bocp_pkg::make_thr(r_cfg.inst_max, r_cfg.avg_max);
    assign w_thr_a   = bocp_pkg::make_thr(r_cfg.inst_a, r_cfg.avg_a);

    assign w_cur[0] = i_sample.current_a;
    assign w_cur[1] = i_sample.current_b;
    assign w_cur[2] = i_sample.current_c;
    assign w_cur[3] = i_sample.current_d;

    for (genvar g = 0; g < bocp_pkg::NUM_LANES; g++) begin : g_lane
        bocp_lane u_lane (
            .i_current (w_cur[g]),
            .i_thr     (w_thr_max),
            .o_flags   (w_lanes[g])
        );
    end

    bocp_lane u_lane_a (
        .i_current (i_sample.current_a),
        .i_thr     (w_thr_a),
        .o_flags   (w_flags_a)
    );

    bocp_merge u_merge (
        .i_lanes  (w_lanes),
        .i_chan_a (w_flags_a),
        .o_cond   (w_cond)
    );

    assign w_s2_take       = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready  = !r_s1_valid || w_s2_take;
    assign w_in_take       = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_s1_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cond <= w_cond;
        end
    end

    bocp_state #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_s2_take),
        .i_cond   (r_cond),
        .i_cfg    (r_cfg),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_take) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.fault_latched     = r_out.fault_latched;
    assign o_result.overcurrent_set   = r_out.overcurrent_set;
    assign o_result.pwm_disable_pulse = r_out.pwm_disable_pulse;
    assign o_result.trip_count        = r_out.trip_count;

    a_pulse_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_take && w_res.pwm_disable_pulse |-> !r_cfg.shutdown)
        else $error("PWM disable pulse issued in latching mode.");

    a_set_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_take && w_res.overcurrent_set |-> w_res.fault_latched)
        else $error("Overcurrent set without a latched fault.");

    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_s1_valid)
        else $error("Accepted sample did not reach the first stage.");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_take |=> r_out_valid)
        else $error("Computed result did not reach the output register.");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bocp_pkg::*;

    typedef struct packed {
        logic signed [CUR_W-1:0] a;
        logic signed [CUR_W-1:0] b;
        logic signed [CUR_W-1:0] c;
        logic signed [CUR_W-1:0] d;
    } t_sample;

    typedef struct {
        int inst_max;
        int inst_a;
        int avg_max;
        int avg_a;
        int long_t;
        int short_t;
        int clear_t;
        bit shutdown;
        bit noise;
        int n_items;
    } t_setting;

    class overcurrent_scoreboard;
        int                     inst_max, inst_a, avg_max, avg_a;
        logic [TICK_W-1:0]      long_ticks, short_ticks, clear_ticks;
        logic                   shutdown;
        logic                   fault;
        logic [COUNT_WIDTH-1:0] long_cnt, short_cnt, release_cnt;
        logic [TRIP_W-1:0]      trip_total;
        t_result                expected_results[$];
        int                     samples, results, errors;

        function new();
            inst_max = 32767;
            inst_a = 32767;
            avg_max = 32767;
            avg_a = 32767;
            long_ticks = RST_TICKS;
            short_ticks = RST_TICKS;
            clear_ticks = RST_TICKS;
            shutdown = 1'b0;
            fault = 1'b0;
            long_cnt = '0;
            short_cnt = '0;
            release_cnt = '0;
            trip_total = '0;
            samples = 0;
            results = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INST_MAX:    inst_max = int'($signed(data[CUR_W-1:0]));
                CFG_INST_A:      inst_a = int'($signed(data[CUR_W-1:0]));
                CFG_AVG_MAX:     avg_max = int'($signed(data[CUR_W-1:0]));
                CFG_AVG_A:       avg_a = int'($signed(data[CUR_W-1:0]));
                CFG_LONG_TICKS:  long_ticks = data[TICK_W-1:0];
                CFG_SHORT_TICKS: short_ticks = data[TICK_W-1:0];
                CFG_CLEAR_TICKS: clear_ticks = data[TICK_W-1:0];
                CFG_SHUTDOWN:    shutdown = data[0];
                default: ;
            endcase
        endfunction

        function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
            return (&c) ? c : c + 1'b1;
        endfunction

        // Advances the protection state by one tick and queues the result it should give.
        function void note_sample(t_sample s);
            int      ca, mx;
            t_result r;
            ca = $signed(s.a);
            mx = ca;
            if ($signed(s.b) > mx) mx = $signed(s.b);
            if ($signed(s.c) > mx) mx = $signed(s.c);
            if ($signed(s.d) > mx) mx = $signed(s.d);
            r.overcurrent_set = 1'b0;
            r.pwm_disable_pulse = 1'b0;
            if (!fault) begin
                if (mx > inst_max || ca > inst_a) begin
                    if (shutdown) begin
                        r.overcurrent_set = 1'b1;
                        fault = 1'b1;
                    end else begin
                        r.pwm_disable_pulse = 1'b1;
                        trip_total = trip_total + 1'b1;
                    end
                end
                if (mx >= avg_max + int'(OFS_LONG_SET) || ca >= avg_a + int'(OFS_LONG_SET)) begin
                    long_cnt = bump(long_cnt);
                end else if (mx <= avg_max + int'(OFS_LONG_CLR)
                             || ca <= avg_a + int'(OFS_LONG_CLR)) begin
                    long_cnt = '0;
                end
                if (long_cnt >= long_ticks) begin
                    r.overcurrent_set = 1'b1;
                    fault = 1'b1;
                end
                if (mx >= avg_max + int'(OFS_SHORT_SET)
                    || ca >= avg_a + int'(OFS_SHORT_SET)) begin
                    short_cnt = bump(short_cnt);
                end else if (mx <= avg_max + int'(OFS_SHORT_CLR)
                             || ca <= avg_a + int'(OFS_SHORT_CLR)) begin
                    short_cnt = '0;
                end
                if (short_cnt >= short_ticks) begin
                    short_cnt = '0;
                    r.overcurrent_set = 1'b1;
                    fault = 1'b1;
                end
                release_cnt = '0;
            end else if (mx <= avg_max - int'(OFS_RELEASE) || ca <= avg_a - int'(OFS_RELEASE)) begin
                release_cnt = bump(release_cnt);
                if (release_cnt >= clear_ticks) begin
                    release_cnt = '0;
                    long_cnt = '0;
                    short_cnt = '0;
                    fault = 1'b0;
                end
            end else begin
                release_cnt = '0;
            end
            r.fault_latched = fault;
            r.trip_count = trip_total;
            expected_results.push_back(r);
            samples++;
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_result(t_result got);
            t_result want;
            results++;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d with no sample waiting, trip_count", results),
                       got.trip_count, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.fault_latched !== want.fault_latched)
                report($sformatf("result %0d fault_latched", results),
                       got.fault_latched, want.fault_latched);
            if (got.overcurrent_set !== want.overcurrent_set)
                report($sformatf("result %0d overcurrent_set", results),
                       got.overcurrent_set, want.overcurrent_set);
            if (got.pwm_disable_pulse !== want.pwm_disable_pulse)
                report($sformatf("result %0d pwm_disable_pulse", results),
                       got.pwm_disable_pulse, want.pwm_disable_pulse);
            if (got.trip_count !== want.trip_count)
                report($sformatf("result %0d trip_count", results),
                       got.trip_count, want.trip_count);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bocp_in_if  smp();
    bocp_out_if res();

    boost_overcurrent_protector_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    overcurrent_scoreboard sb = new();

    int       src_idle_pct;
    int       sink_stall_pct;
    int       rcv_hold;
    t_setting cur;
    int       lvl;
    int       lvl_a;
    int       run_left;
    int       level_steps[$] = '{-400, -129, -128, -127, -60, 0, 31, 32, 33, 47, 48, 60,
                                 79, 80, 81, 95, 96, 150, 400};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (rcv_hold > 0) begin
            rcv_hold = rcv_hold - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_result(t_result'{res.fault_latched, res.overcurrent_set,
                                      res.pwm_disable_pulse, res.trip_count});
    end

    function automatic logic signed [CUR_W-1:0] to_current(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return CUR_W'(v);
    endfunction

    function automatic t_sample mk(int a, int b, int c, int d);
        return t_sample'{to_current(a), to_current(b), to_current(c), to_current(d)};
    endfunction

    // Mostly runs of samples held near the persistence and release thresholds,
    // with some samples at the trip levels and some pure noise.
    function automatic t_sample next_sample();
        t_sample s;
        int      pick, jit, hot;
        pick = $urandom_range(99);
        if (cur.noise || pick < 10) begin
            s = {$urandom(), $urandom()};
        end else if (pick < 22) begin
            s.a = to_current(cur.inst_a + int'($urandom_range(0, 2)) - 1);
            s.b = to_current(cur.inst_max + int'($urandom_range(0, 2)) - 1);
            s.c = to_current(cur.inst_max - int'($urandom_range(0, 300)));
            s.d = to_current(cur.avg_max + lvl);
        end else begin
            if (run_left == 0) begin
                lvl = level_steps[$urandom_range(0, level_steps.size() - 1)];
                lvl_a = ($urandom_range(3) == 0)
                        ? level_steps[$urandom_range(0, level_steps.size() - 1)] : lvl;
                run_left = $urandom_range(1, 25);
            end
            run_left--;
            jit = int'($urandom_range(0, 4)) - 2;
            hot = $urandom_range(1, 3);
            s.a = to_current(cur.avg_a + lvl_a + jit);
            s.b = to_current(cur.avg_max + lvl + jit - (hot == 1 ? 0 : int'($urandom_range(0, 200))));
            s.c = to_current(cur.avg_max + lvl + jit - (hot == 2 ? 0 : int'($urandom_range(0, 200))));
            s.d = to_current(cur.avg_max + lvl + jit - (hot == 3 ? 0 : int'($urandom_range(0, 200))));
        end
        return s;
    endfunction

    task automatic send_sample(t_sample s);
        while ($urandom_range(99) < src_idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.current_a <= s.a;
        smp.current_b <= s.b;
        smp.current_c <= s.c;
        smp.current_d <= s.d;
        do @(posedge i_clk); while (!smp.ready);
        sb.note_sample(s);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        sb.write_reg(idx, CFG_DATA_W'(value));
        @(negedge i_clk);
    endtask

    task automatic apply_setting(t_setting s);
        smp.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(CFG_INST_MAX, s.inst_max);
        write_reg(CFG_INST_A, s.inst_a);
        write_reg(CFG_AVG_MAX, s.avg_max);
        write_reg(CFG_AVG_A, s.avg_a);
        write_reg(CFG_LONG_TICKS, s.long_t);
        write_reg(CFG_SHORT_TICKS, s.short_t);
        write_reg(CFG_CLEAR_TICKS, s.clear_t);
        write_reg(CFG_SHUTDOWN, int'(s.shutdown));
        i_cfg_we <= 1'b0;
        cur = s;
        run_left = 0;
    endtask

    initial begin
        t_setting plan[$];
        t_sample  directed[$];
        t_setting dir_pulse, dir_latch;
        int       src_pct[4] = '{0, 55, 0, 26};
        int       sink_pct[4] = '{0, 0, 55, 26};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        smp.valid = 1'b0;
        smp.current_a = '0;
        smp.current_b = '0;
        smp.current_c = '0;
        smp.current_d = '0;
        res.ready = 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        rcv_hold = 0;
        lvl = 0;
        lvl_a = 0;
        run_left = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample(mk(32767, 32767, 32767, 32767));
        send_sample(mk(-32768, -32768, -32768, -32768));

        dir_pulse = t_setting'{1000, 800, 500, 400, 3, 2, 2, 1'b0, 1'b0, 0};
        dir_latch = dir_pulse;
        dir_latch.shutdown = 1'b1;
        directed = '{mk(-32768, -32768, -32768, -32768), mk(32767, 32767, 32767, 32767),
                     mk(0, 0, 0, 1001), mk(-32768, 0, 0, 0), mk(272, 272, 372, 372),
                     mk(448, 0, 0, 0), mk(433, 547, 0, 0), mk(0, 548, 0, 0),
                     mk(432, 532, 0, 0), mk(800, 1000, 1000, 1000), mk(801, 0, 0, 0),
                     mk(-1, -1, -1, -1), mk(-1, -1, -1, -1),
                     mk(21845, -21846, 21845, -21846), mk(-21846, 21845, -21846, 21845),
                     mk(0, 0, 0, 0)};
        apply_setting(dir_pulse);
        foreach (directed[i]) send_sample(directed[i]);
        directed = '{mk(801, 0, 0, 0), mk(272, 0, 0, 0), mk(300, 400, 0, 0),
                     mk(0, 0, 0, 0), mk(0, 0, 0, 0), mk(0, 0, 1001, 0)};
        apply_setting(dir_latch);
        foreach (directed[i]) send_sample(directed[i]);

        plan.push_back(t_setting'{1200, 900, 300, 200, 5, 3, 4, 1'b1, 1'b0, 100});
        plan.push_back(t_setting'{30000, 30000, -100, -200, 10, 4, 6, 1'b0, 1'b0, 100});
        plan.push_back(t_setting'{-32768, 32767, -32768, -32768, 1, 1, 1, 1'b0, 1'b0, 100});
        plan.push_back(t_setting'{32767, -32768, 32767, 32767, 16777215, 16777215, 16777215,
                                  1'b1, 1'b0, 100});
        plan.push_back(t_setting'{0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 100});
        plan.push_back(t_setting'{2000, 1500, 1000, 1100, 20, 8, 12, 1'b0, 1'b0, 100});
        plan.push_back(t_setting'{500, -500, -1000, -1200, 2, 1, 3, 1'b1, 1'b0, 100});
        plan.push_back(t_setting'{-20000, -18000, -21000, -19000, 7, 3, 2, 1'b0, 1'b0, 100});
        plan.push_back(t_setting'{100, 100, -60, 60, 16777215, 1, 1, 1'b0, 1'b0, 100});
        plan.push_back(t_setting'{-32768, 32767, 32767, 32767, 16777215, 16777215, 16777215,
                                  1'b0, 1'b1, 40});

        foreach (plan[p]) begin
            apply_setting(plan[p]);
            src_idle_pct = plan[p].noise ? 0 : src_pct[p % 4];
            sink_stall_pct = plan[p].noise ? 0 : sink_pct[p % 4];
            if (p % 4 == 0 && !plan[p].noise) rcv_hold = 80;
            repeat (plan[p].n_items) send_sample(next_sample());
        end

        smp.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d samples and %0d checked results over %0d register settings,",
                 sb.samples, sb.results, plan.size() + 3);
        $display("with trip levels, persistence hysteresis, release runs and random noise.");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
